FILE: src/acs_pkg.sv
// shared types and constants for the box/sphere contact pipeline
`default_nettype none
package acs_pkg;

  localparam int ROOT_STEPS = 32;
  localparam int QUO_BITS   = 31;
  localparam logic signed [43:0] GAIN = 44'sd1000;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [2:0][33:0] e;
    logic [2:0]       dneg;
    logic [2:0][31:0] a;
    logic [30:0]      dia;
    logic [1:0]       axis;
    logic             neg;
    logic             degen;
    logic             hit;
    logic             far;
    logic [2:0][61:0] sq;
    logic [61:0]      dia2;
    logic [31:0]      m;
    logic             right;
    logic [4:0]       left;
    logic [63:0]      rad;
    logic [34:0]      rem;
    logic [31:0]      root;
    logic [31:0]      len;
    logic [2:0][30:0] num;
    logic [2:0][32:0] drem;
    logic [2:0][30:0] quo;
    logic [2:0][63:0] psq;
  } tok_t;

endpackage
`default_nettype wire

FILE: src/acs_if.sv
// handshake channels for pair beats and result beats
`default_nettype none
interface acs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] box_x;
  logic [31:0] box_y;
  logic [31:0] box_z;
  logic [30:0] half_x;
  logic [30:0] half_y;
  logic [30:0] half_z;
  logic [31:0] ball_x;
  logic [31:0] ball_y;
  logic [31:0] ball_z;
  logic [30:0] diameter;
  modport source (output valid, box_x, box_y, box_z, half_x, half_y, half_z,
                  ball_x, ball_y, ball_z, diameter, input ready);
  modport sink (input valid, box_x, box_y, box_z, half_x, half_y, half_z,
                ball_x, ball_y, ball_z, diameter, output ready);
endinterface

interface acs_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [1:0]  normal_axis;
  logic        normal_negative;
  logic [31:0] penetration;
  logic        degenerate;
  modport source (output valid, hit, normal_axis, normal_negative, penetration,
                  degenerate, input ready);
  modport sink (input valid, hit, normal_axis, normal_negative, penetration,
                degenerate, output ready);
endinterface
`default_nettype wire

FILE: src/acs_front.sv
// front stages: offsets, contact, hit test, axis pick and direction normalize
`default_nettype none
module acs_front
  import acs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  acs_in_if.sink    req,
  output logic      out_vld,
  input  wire logic out_rdy,
  output tok_t      out_tok
);

  localparam int NS = 6;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;
  tok_t          tok [NS];
  tok_t          nxt [NS];

  function automatic logic [4:0] msb_pos(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  // stage 0: offsets and clamped contact
  always_comb begin
    logic [2:0][31:0] box;
    logic [2:0][31:0] ball;
    logic [2:0][30:0] half;
    logic signed [32:0] d;
    logic signed [43:0] dx;
    logic signed [43:0] t;
    logic signed [43:0] h;
    logic signed [43:0] ex;
    box[0] = req.box_x;   box[1] = req.box_y;   box[2] = req.box_z;
    ball[0] = req.ball_x; ball[1] = req.ball_y; ball[2] = req.ball_z;
    half[0] = req.half_x; half[1] = req.half_y; half[2] = req.half_z;
    nxt[0] = '0;
    nxt[0].dia = req.diameter;
    for (int i = 0; i < 3; i++) begin
      d  = $signed({ball[i][31], ball[i]}) - $signed({box[i][31], box[i]});
      dx = 44'(d);
      t  = dx * GAIN;
      h  = $signed({13'b0, half[i]});
      if (t > h) t = h;
      if (t < -h) t = -h;
      ex = dx - t;
      nxt[0].e[i]    = ex[33:0];
      nxt[0].dneg[i] = d[32];
      nxt[0].a[i]    = d[32] ? 32'(-d) : d[31:0];
    end
  end

  // stage 1: error squares, axis, largest offset
  always_comb begin
    logic [33:0] em;
    logic [1:0]  ax;
    logic [31:0] mx;
    nxt[1] = tok[0];
    nxt[1].far = 1'b0;
    for (int i = 0; i < 3; i++) begin
      em = tok[0].e[i][33] ? -tok[0].e[i] : tok[0].e[i];
      if (em[33:31] != 3'b0) nxt[1].far = 1'b1;
      nxt[1].sq[i] = em[30:0] * em[30:0];
    end
    nxt[1].dia2 = tok[0].dia * tok[0].dia;
    ax = (tok[0].a[0] > tok[0].a[1]) ? AXIS_X : AXIS_Y;
    if (tok[0].a[ax] < tok[0].a[2]) ax = AXIS_Z;
    nxt[1].axis  = ax;
    nxt[1].neg   = tok[0].dneg[ax];
    nxt[1].degen = (tok[0].a[0] | tok[0].a[1] | tok[0].a[2]) == 32'b0;
    mx = tok[0].a[0];
    if (tok[0].a[1] > mx) mx = tok[0].a[1];
    if (tok[0].a[2] > mx) mx = tok[0].a[2];
    nxt[1].m = mx;
  end

  // stage 2: hit compare and shift amount
  always_comb begin
    logic [63:0] s;
    s = {2'b0, tok[1].sq[0]} + {2'b0, tok[1].sq[1]} + {2'b0, tok[1].sq[2]};
    nxt[2] = tok[1];
    nxt[2].hit   = !tok[1].far && (s <= {4'b0, tok[1].dia2[61:2]});
    nxt[2].right = tok[1].m[31];
    nxt[2].left  = (tok[1].m[31] || tok[1].m == 32'b0) ? 5'd0
                                                         : 5'd30 - msb_pos(tok[1].m);
  end

  // stage 3: normalize direction
  always_comb begin
    nxt[3] = tok[2];
    for (int i = 0; i < 3; i++) begin
      nxt[3].a[i] = tok[2].right ? (tok[2].a[i] >> 1) : (tok[2].a[i] << tok[2].left);
    end
  end

  // stage 4: direction squares
  always_comb begin
    nxt[4] = tok[3];
    for (int i = 0; i < 3; i++) begin
      nxt[4].sq[i] = tok[3].a[i][30:0] * tok[3].a[i][30:0];
    end
  end

  // stage 5: squared length into the root row
  always_comb begin
    nxt[5] = tok[4];
    nxt[5].rad  = {2'b0, tok[4].sq[0]} + {2'b0, tok[4].sq[1]} + {2'b0, tok[4].sq[2]};
    nxt[5].rem  = '0;
    nxt[5].root = '0;
  end

  assign rdy[NS] = out_rdy;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    assign rdy[k] = !vld[k] || rdy[k+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= (k == 0) ? req.valid : vld[(k == 0) ? 0 : k-1];
      end
      if (rdy[k]) begin
        tok[k] <= nxt[k];
      end
    end
  end

  assign req.ready = rdy[0];
  assign out_vld   = vld[NS-1];
  assign out_tok   = tok[NS-1];

endmodule
`default_nettype wire

FILE: src/acs_root_cell.sv
// one digit step of the integer square root row
`default_nettype none
module acs_root_cell
  import acs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_vld,
  output logic      in_rdy,
  input  tok_t      in_tok,
  output logic      out_vld,
  input  wire logic out_rdy,
  output tok_t      out_tok
);

  tok_t nxt;

  always_comb begin
    logic [34:0] r;
    logic [34:0] trial;
    nxt   = in_tok;
    r     = {in_tok.rem[32:0], in_tok.rad[63:62]};
    trial = {1'b0, in_tok.root, 2'b01};
    nxt.rad = {in_tok.rad[61:0], 2'b00};
    if (r >= trial) begin
      nxt.rem  = r - trial;
      nxt.root = {in_tok.root[30:0], 1'b1};
    end else begin
      nxt.rem  = r;
      nxt.root = {in_tok.root[30:0], 1'b0};
    end
  end

  assign in_rdy = !out_vld || out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (in_rdy) begin
      out_vld <= in_vld;
    end
    if (in_rdy) begin
      out_tok <= nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/acs_scale.sv
// scaled numerators for the three quotient lanes
`default_nettype none
module acs_scale
  import acs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_vld,
  output logic      in_rdy,
  input  tok_t      in_tok,
  output logic      out_vld,
  input  wire logic out_rdy,
  output tok_t      out_tok
);

  tok_t nxt;

  always_comb begin
    logic [61:0] p;
    nxt     = in_tok;
    nxt.len = in_tok.root;
    for (int i = 0; i < 3; i++) begin
      p = in_tok.dia * in_tok.a[i][30:0];
      nxt.drem[i] = {2'b0, p[61:31]};
      nxt.num[i]  = p[30:0];
      nxt.quo[i]  = '0;
    end
  end

  assign in_rdy = !out_vld || out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (in_rdy) begin
      out_vld <= in_vld;
    end
    if (in_rdy) begin
      out_tok <= nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/acs_div_cell.sv
// one restoring step of the three quotient lanes
`default_nettype none
module acs_div_cell
  import acs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_vld,
  output logic      in_rdy,
  input  tok_t      in_tok,
  output logic      out_vld,
  input  wire logic out_rdy,
  output tok_t      out_tok
);

  tok_t nxt;

  always_comb begin
    logic [32:0] r;
    logic        ge;
    nxt = in_tok;
    for (int i = 0; i < 3; i++) begin
      r  = {in_tok.drem[i][31:0], in_tok.num[i][30]};
      ge = r >= {1'b0, in_tok.len};
      nxt.drem[i] = ge ? r - {1'b0, in_tok.len} : r;
      nxt.num[i]  = {in_tok.num[i][29:0], 1'b0};
      nxt.quo[i]  = {in_tok.quo[i][29:0], ge};
    end
  end

  assign in_rdy = !out_vld || out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (in_rdy) begin
      out_vld <= in_vld;
    end
    if (in_rdy) begin
      out_tok <= nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/acs_back.sv
// back stages: penetration vector, its squares and saturated sum
`default_nettype none
module acs_back
  import acs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_vld,
  output logic      in_rdy,
  input  tok_t      in_tok,
  output logic      out_vld,
  input  wire logic out_rdy,
  output tok_t      out_tok
);

  localparam int NS = 3;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;
  tok_t          tok [NS];
  tok_t          nxt [NS];

  // stage 0: p = e - signed quotient, kept as magnitude in a
  always_comb begin
    logic [33:0] q;
    logic [33:0] p;
    nxt[0] = in_tok;
    for (int i = 0; i < 3; i++) begin
      q = in_tok.dneg[i] ? -{3'b0, in_tok.quo[i]} : {3'b0, in_tok.quo[i]};
      p = in_tok.e[i] - q;
      nxt[0].a[i] = p[33] ? 32'(-p) : p[31:0];
    end
  end

  // stage 1: squares
  always_comb begin
    nxt[1] = tok[0];
    for (int i = 0; i < 3; i++) begin
      nxt[1].psq[i] = tok[0].a[i] * tok[0].a[i];
    end
  end

  // stage 2: saturated sum into the root row
  always_comb begin
    logic [65:0] s;
    s = {2'b0, tok[1].psq[0]} + {2'b0, tok[1].psq[1]} + {2'b0, tok[1].psq[2]};
    nxt[2] = tok[1];
    nxt[2].rad  = (s[65:64] != 2'b0) ? '1 : s[63:0];
    nxt[2].rem  = '0;
    nxt[2].root = '0;
  end

  assign rdy[NS] = out_rdy;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    assign rdy[k] = !vld[k] || rdy[k+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= (k == 0) ? in_vld : vld[(k == 0) ? 0 : k-1];
      end
      if (rdy[k]) begin
        if (k == 0) tok[k] <= nxt[0];
        else tok[k] <= nxt[k];
      end
    end
  end

  assign in_rdy  = rdy[0];
  assign out_vld = vld[NS-1];
  assign out_tok = tok[NS-1];

endmodule
`default_nettype wire

FILE: src/aabb_sphere_collision.sv
// top level: box/sphere contact test as a row of pipeline cells
// Takes one box/sphere pair per cycle while the row is not stalled and
// returns one result beat per pair, in order. The row holds six front stages,
// 32 square root digit cells for the offset length, one scaling stage, 31
// restoring divide cells working three lanes at once, three back stages and
// 32 more root cells for the penetration depth; the last root cell is the
// output register. Every cell has its own valid bit, so a held result stalls
// only the cells behind it and the input keeps taking pairs until the row is
// full.
`default_nettype none
module aabb_sphere_collision
  import acs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  acs_in_if.sink    req,
  acs_out_if.source rsp
);

  logic f_vld;
  logic f_rdy;
  tok_t f_tok;

  logic [ROOT_STEPS:0] r1_vld;
  logic [ROOT_STEPS:0] r1_rdy;
  tok_t                r1_tok [ROOT_STEPS+1];

  logic [QUO_BITS:0] d_vld;
  logic [QUO_BITS:0] d_rdy;
  tok_t              d_tok [QUO_BITS+1];

  logic [ROOT_STEPS:0] r2_vld;
  logic [ROOT_STEPS:0] r2_rdy;
  tok_t                r2_tok [ROOT_STEPS+1];

  acs_front u_front (
    .clk, .rst, .req,
    .out_vld(f_vld), .out_rdy(f_rdy), .out_tok(f_tok)
  );

  assign r1_vld[0] = f_vld;
  assign f_rdy     = r1_rdy[0];
  assign r1_tok[0] = f_tok;

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_len
    acs_root_cell u_cell (
      .clk, .rst,
      .in_vld(r1_vld[k]), .in_rdy(r1_rdy[k]), .in_tok(r1_tok[k]),
      .out_vld(r1_vld[k+1]), .out_rdy(r1_rdy[k+1]), .out_tok(r1_tok[k+1])
    );
  end

  acs_scale u_scale (
    .clk, .rst,
    .in_vld(r1_vld[ROOT_STEPS]), .in_rdy(r1_rdy[ROOT_STEPS]),
    .in_tok(r1_tok[ROOT_STEPS]),
    .out_vld(d_vld[0]), .out_rdy(d_rdy[0]), .out_tok(d_tok[0])
  );

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    acs_div_cell u_cell (
      .clk, .rst,
      .in_vld(d_vld[k]), .in_rdy(d_rdy[k]), .in_tok(d_tok[k]),
      .out_vld(d_vld[k+1]), .out_rdy(d_rdy[k+1]), .out_tok(d_tok[k+1])
    );
  end

  acs_back u_back (
    .clk, .rst,
    .in_vld(d_vld[QUO_BITS]), .in_rdy(d_rdy[QUO_BITS]), .in_tok(d_tok[QUO_BITS]),
    .out_vld(r2_vld[0]), .out_rdy(r2_rdy[0]), .out_tok(r2_tok[0])
  );

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_pen
    acs_root_cell u_cell (
      .clk, .rst,
      .in_vld(r2_vld[k]), .in_rdy(r2_rdy[k]), .in_tok(r2_tok[k]),
      .out_vld(r2_vld[k+1]), .out_rdy(r2_rdy[k+1]), .out_tok(r2_tok[k+1])
    );
  end

  assign r2_rdy[ROOT_STEPS] = rsp.ready;
  assign rsp.valid           = r2_vld[ROOT_STEPS];
  assign rsp.hit             = r2_tok[ROOT_STEPS].hit;
  assign rsp.degenerate      = r2_tok[ROOT_STEPS].degen;
  assign rsp.normal_axis     = r2_tok[ROOT_STEPS].degen ? AXIS_X : r2_tok[ROOT_STEPS].axis;
  assign rsp.normal_negative = !r2_tok[ROOT_STEPS].degen && r2_tok[ROOT_STEPS].neg;
  assign rsp.penetration     = (r2_tok[ROOT_STEPS].hit && !r2_tok[ROOT_STEPS].degen)
                               ? r2_tok[ROOT_STEPS].root : 32'b0;

endmodule
`default_nettype wire
